FILE: design/step_sequencer_index_generator_top_macros.svh
// assertion helpers for the step sequencer index generator
`ifndef STEP_SEQUENCER_INDEX_GENERATOR_TOP_MACROS_SVH
`define STEP_SEQUENCER_INDEX_GENERATOR_TOP_MACROS_SVH

// same-cycle implication, checked outside reset
`define SIS_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("step sequencer check failed");

// next-cycle implication, checked outside reset
`define SIS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("step sequencer check failed");

`endif

FILE: design/sis_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sis_pkg;

  localparam int unsigned MaxSteps  = 16;
  localparam int unsigned MinSteps  = 1;
  localparam int unsigned CountW    = 5;
  localparam int unsigned IdxW      = 5;
  localparam int unsigned OutW      = 4;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 5;
  localparam int unsigned RandW     = 32;
  localparam logic [RandW-1:0] SeedValue = 32'h0030_3303;
  localparam int unsigned ShiftA    = 13;
  localparam int unsigned ShiftB    = 17;
  localparam int unsigned ShiftC    = 5;

  // remainder unit: digits of DigitBits bits, one digit per cycle
  localparam int unsigned DigitBits  = 4;
  localparam int unsigned DigitCount = RandW / DigitBits;
  localparam int unsigned DigitCntW  = $clog2(DigitCount);

  localparam logic [CfgIdxW-1:0] CFG_STEP_COUNT = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_PLAY_MODE  = 2'd1;

  localparam logic ACT_ADVANCE = 1'b0;
  localparam logic ACT_QUERY   = 1'b1;

  typedef enum logic [1:0] {
    MODE_FORWARD  = 2'd0,
    MODE_REVERSE  = 2'd1,
    MODE_PINGPONG = 2'd2,
    MODE_RANDOM   = 2'd3
  } play_mode_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_WRITE
  } seq_state_e;

endpackage

`default_nettype wire

FILE: design/step_sequencer_index_generator_top.sv
`timescale 1ns / 1ps
`default_nettype none

// Step sequencer index generator. Each input item carries a current step and an action and
// gives one result item: the next step for the play mode (forward, reverse, ping-pong or
// random) or, for a query, the previous step. Non-random results are registered on acceptance
// and then loaded into the output register. For a random item the accepting cycle draws a new
// xorshift32 value and starts an iterative remainder unit, which reduces it modulo the clamped
// step count four bits per cycle. Input stall stays high from acceptance until the result is
// loaded into the output register; that register holds one result while the next item is
// accepted. Configuration writes are taken in every cycle and must only occur while idle.
module step_sequencer_index_generator_top
  import sis_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire logic                action_i,
  input  wire logic [IdxW-1:0]     current_index_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output logic      [OutW-1:0]     step_index_o,
  input  wire logic                cfg_valid_i,
  output logic                     cfg_ready_o,
  input  wire logic [CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i
);

`include "step_sequencer_index_generator_top_macros.svh"

  seq_state_e        state_q, state_d;
  logic [CountW-1:0] step_count_q;
  play_mode_e        play_mode_q;
  logic              bounce_q, bounce_d;
  logic [OutW-1:0]   res_q, res_d;
  logic              out_valid_q, out_valid_d;
  logic [OutW-1:0]   out_data_q;
  logic              out_load;

  logic              in_accept;
  logic [CountW-1:0] len;
  logic              no_cur;
  logic [CountW-1:0] len_m1;
  logic [CountW-1:0] cur_m1;
  logic [CountW-1:0] cur_p1;
  logic signed [6:0] len_s;
  logic signed [6:0] cur_s;
  logic signed [6:0] pp_n;
  logic              pp_down;

  logic              draw;
  logic              mod_start;
  logic [RandW-1:0]  rand_value;
  logic              mod_done;
  logic [OutW-1:0]   mod_rem;

  assign in_accept   = in_valid_i && !in_stall_o;
  assign in_stall_o  = (state_q != ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign step_index_o = out_data_q;

  // clamped step count
  always_comb begin
    if (step_count_q < CountW'(MinSteps)) begin
      len = CountW'(MinSteps);
    end else if (step_count_q > CountW'(MaxSteps)) begin
      len = CountW'(MaxSteps);
    end else begin
      len = step_count_q;
    end
  end

  assign no_cur = (current_index_i >= len);
  assign len_m1 = len - CountW'(1);
  assign cur_m1 = current_index_i - CountW'(1);
  assign cur_p1 = current_index_i + CountW'(1);
  assign len_s  = signed'({2'b00, len});
  assign cur_s  = signed'({2'b00, current_index_i});

  // ping-pong next step and direction
  always_comb begin
    pp_down = bounce_q;
    if (no_cur) begin
      pp_n    = 7'sd0;
      pp_down = 1'b0;
    end else begin
      pp_n = bounce_q ? (cur_s - 7'sd1) : (cur_s + 7'sd1);
      if (pp_n >= len_s) begin
        pp_down = 1'b1;
        pp_n    = len_s - 7'sd2;
      end else if (pp_n < 7'sd0) begin
        pp_down = 1'b0;
        pp_n    = 7'sd1;
      end
      if (pp_n < 7'sd0) begin
        pp_n = pp_n + len_s;
      end
      if (pp_n >= len_s) begin
        pp_n = pp_n - len_s;
      end
      if (pp_n < 7'sd0 || pp_n >= len_s) begin
        pp_n = 7'sd0;
      end
    end
  end

  always_comb begin
    state_d     = state_q;
    bounce_d    = bounce_q;
    res_d       = res_q;
    draw        = 1'b0;
    mod_start   = 1'b0;
    out_load    = 1'b0;
    out_valid_d = out_valid_q && out_stall_i;
    unique case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          state_d = ST_WRITE;
          if (action_i == ACT_QUERY) begin
            res_d = (no_cur || current_index_i == '0) ? len_m1[OutW-1:0] : cur_m1[OutW-1:0];
          end else begin
            unique case (play_mode_q)
              MODE_FORWARD: begin
                res_d = (no_cur || cur_p1 == len) ? '0 : cur_p1[OutW-1:0];
              end
              MODE_REVERSE: begin
                res_d = (no_cur || current_index_i == '0) ? len_m1[OutW-1:0]
                                                           : cur_m1[OutW-1:0];
              end
              MODE_PINGPONG: begin
                res_d    = pp_n[OutW-1:0];
                bounce_d = pp_down;
              end
              MODE_RANDOM: begin
                draw      = 1'b1;
                mod_start = 1'b1;
                state_d   = ST_DIVIDE;
              end
              default: begin
                res_d = '0;
              end
            endcase
          end
        end
      end
      ST_DIVIDE: begin
        if (mod_done) begin
          res_d   = mod_rem;
          state_d = ST_WRITE;
        end
      end
      ST_WRITE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load    = 1'b1;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      bounce_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      bounce_q    <= bounce_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_count_q <= CountW'(MaxSteps);
      play_mode_q  <= MODE_FORWARD;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_STEP_COUNT: step_count_q <= cfg_data_i[CountW-1:0];
        CFG_PLAY_MODE:  play_mode_q  <= play_mode_e'(cfg_data_i[1:0]);
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    if (out_load) begin
      out_data_q <= res_q;
    end
  end

  sis_xorshift u_xorshift (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .draw_i  (draw),
    .value_o (rand_value)
  );

  sis_mod_unit u_mod_unit (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (mod_start),
    .dividend_i (rand_value),
    .divisor_i  (len),
    .done_o     (mod_done),
    .rem_o      (mod_rem)
  );

  `SIS_ASSERT_NEXT(a_accept_leaves_idle, in_accept, state_q != ST_IDLE)
  `SIS_ASSERT_SAME(a_done_only_dividing, mod_done, state_q == ST_DIVIDE)
  `SIS_ASSERT_NEXT(a_write_fills_output, state_q == ST_WRITE && !out_valid_q, out_valid_q)

endmodule

`default_nettype wire

FILE: design/sis_xorshift.sv
`timescale 1ns / 1ps
`default_nettype none

module sis_xorshift
  import sis_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             draw_i,
  output logic      [RandW-1:0] value_o
);

  logic [RandW-1:0] state_q;
  logic [RandW-1:0] seed;
  logic [RandW-1:0] s1;
  logic [RandW-1:0] s2;

  always_comb begin
    seed    = (state_q == '0) ? SeedValue : state_q;
    s1      = seed ^ (seed << ShiftA);
    s2      = s1 ^ (s1 >> ShiftB);
    value_o = s2 ^ (s2 << ShiftC);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SeedValue;
    end else if (draw_i) begin
      state_q <= value_o;
    end
  end

endmodule

`default_nettype wire

FILE: design/sis_mod_unit.sv
`timescale 1ns / 1ps
`default_nettype none

module sis_mod_unit
  import sis_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire logic [RandW-1:0]  dividend_i,
  input  wire logic [CountW-1:0] divisor_i,
  output logic                   done_o,
  output logic      [OutW-1:0]   rem_o
);

  logic                 busy_q;
  logic [DigitCntW-1:0] cnt_q;
  logic [RandW-1:0]     dividend_q;
  logic [OutW-1:0]      rem_q;
  logic [CountW-1:0]    divisor_q;
  logic [CountW-1:0]    part;
  logic [OutW-1:0]      rem_next;

  // one digit per cycle, msb first, remainder stays below the divisor
  always_comb begin
    rem_next = rem_q;
    for (int k = 0; k < DigitBits; k++) begin
      part = {rem_next, dividend_q[RandW-1-k]};
      if (part >= divisor_q) begin
        part = part - divisor_q;
      end
      rem_next = part[OutW-1:0];
    end
  end

  assign done_o = busy_q && (cnt_q == DigitCntW'(DigitCount - 1));
  assign rem_o  = rem_next;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (busy_q) begin
      busy_q <= !done_o;
      cnt_q  <= cnt_q + DigitCntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dividend_q <= dividend_i;
      divisor_q  <= divisor_i;
      rem_q      <= '0;
    end else if (busy_q) begin
      dividend_q <= dividend_q << DigitBits;
      rem_q      <= rem_next;
    end
  end

endmodule

`default_nettype wire
